>>> rtl/core/dbmc_pkg.sv
// ----------------------------------------------------------------------------
// dbmc_pkg
// shared types, constants and helper functions of the maze carver
// ----------------------------------------------------------------------------
`default_nettype none

package dbmc_pkg;

    localparam int MAX_COLS = 32;
    localparam int MAX_ROWS = 32;
    localparam int CELL_CAP = MAX_COLS * MAX_ROWS;
    localparam int CELL_W   = $clog2(CELL_CAP);
    localparam int DEPTH_W  = $clog2(CELL_CAP + 1);
    localparam int DIM_W    = 6;
    localparam int RND_W    = 16;
    localparam int WALL_W   = 4;
    localparam int DIVC_W   = $clog2(CELL_W + 1);

    // action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // register indexes
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // wall bits
    localparam logic [WALL_W-1:0] W_TOP    = 4'b1000;
    localparam logic [WALL_W-1:0] W_RIGHT  = 4'b0100;
    localparam logic [WALL_W-1:0] W_BOTTOM = 4'b0010;
    localparam logic [WALL_W-1:0] W_LEFT   = 4'b0001;
    localparam logic [WALL_W-1:0] W_ALL    = 4'b1111;

    // neighbour order
    localparam logic [1:0] DIR_L = 2'd0;
    localparam logic [1:0] DIR_R = 2'd1;
    localparam logic [1:0] DIR_U = 2'd2;
    localparam logic [1:0] DIR_D = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_SWEEP,
        ST_IDLE,
        ST_START_FIN,
        ST_POP,
        ST_POP_CAP,
        ST_DIV,
        ST_NB_RD,
        ST_NB_CAP,
        ST_WR_CUR,
        ST_WR_NB,
        ST_CELL_RD,
        ST_CELL_CAP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr_init;
        logic clr_write;
        logic take_in;
        logic start_fin;
        logic pop_rd;
        logic pop_cap;
        logic div_step;
        logic nb_rd;
        logic nb_cap;
        logic wr_cur;
        logic wr_nb;
        logic cell_rd;
        logic cell_cap;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       div_last;
        logic       nb_last;
        logic       any_nb;
        logic       stack_empty;
        logic [1:0] in_action;
        logic       out_free;
    } sts_t;

    function automatic logic [WALL_W-1:0] mine_wall(input logic [1:0] dir);
        logic [WALL_W-1:0] w;
        case (dir)
            DIR_L:   w = W_LEFT;
            DIR_R:   w = W_RIGHT;
            DIR_U:   w = W_TOP;
            DIR_D:   w = W_BOTTOM;
            default: w = W_LEFT;
        endcase
        return w;
    endfunction

    function automatic logic [WALL_W-1:0] their_wall(input logic [1:0] dir);
        logic [WALL_W-1:0] w;
        case (dir)
            DIR_L:   w = W_RIGHT;
            DIR_R:   w = W_LEFT;
            DIR_U:   w = W_BOTTOM;
            DIR_D:   w = W_TOP;
            default: w = W_RIGHT;
        endcase
        return w;
    endfunction

    // picks open neighbour number rnd mod count, in list order
    function automatic logic [1:0] pick_dir(input logic [3:0] ok, input logic [RND_W-1:0] rnd);
        logic [2:0] n;
        logic [4:0] s;
        logic [2:0] t;
        logic [1:0] k;
        logic [2:0] seen;
        logic [1:0] dir;
        n = 3'(ok[0]) + 3'(ok[1]) + 3'(ok[2]) + 3'(ok[3]);
        // mod 3 by digit sum in base 4
        s = '0;
        for (int i = 0; i < RND_W / 2; i++) begin
            s = s + 5'(rnd[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        case (n)
            3'd2:    k = {1'b0, rnd[0]};
            3'd3:    k = t[1:0];
            3'd4:    k = rnd[1:0];
            default: k = 2'd0;
        endcase
        dir  = DIR_L;
        seen = '0;
        for (int i = 0; i < 4; i++) begin
            if (ok[i]) begin
                if (seen == {1'b0, k}) begin
                    dir = 2'(i);
                end
                seen = seen + 3'd1;
            end
        end
        return dir;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/dfs_backtracker_maze_carver.sv
// ----------------------------------------------------------------------------
// dfs_backtracker_maze_carver
// maze carver by randomized depth-first search with an explicit cell stack
// ----------------------------------------------------------------------------
// Takes one word at a time and returns exactly one result word for it. A start
// word sweeps the cell memory, one entry a cycle, to clear all visited marks
// and raise all walls, then pushes cell 0 ahead of the result load. A step
// word pops the stack top, splits it into x and y with a bit-serial divider by
// the column count, reads the four neighbour entries and the popped cell one at
// a time through the single cell memory port, then writes back both walls and
// pushes; a backtrack skips the writes, and an empty stack goes straight to the
// result load. A read word reads one cell entry. The divider and the one cell
// memory port set the length of a step; a result that still waits on m_tready
// holds the next one back. After reset the same clearing pass runs before the
// first word is taken; configuration writes are taken at any time. The result
// register lets the next word in while a result still waits on m_tready.
`default_nettype none

module dfs_backtracker_maze_carver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: index 0 grid_cols, index 1 grid_rows
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [5:0]  cfg_wdata,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // random_value[15:0], cell_index[25:16]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // from_cell[9:0], to_cell[19:10],
                                        // wall_bits[23:20], depth_now[34:24]
    output logic [0:0]       m_tuser,   // advanced[0]
    output logic             m_tlast    // done_res
);

    dbmc_pkg::cmd_t cmd;
    dbmc_pkg::sts_t sts;

    // sequencer
    dbmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // memories, divider and result register
    dbmc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // done flag agrees with the reported depth
    a_done_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[34:24] == 11'd0)))
        else $error("done flag and depth disagree");

    // a carve leaves at least two entries on the stack
    a_adv_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[34:24] >= 11'd2))
        else $error("advance with shallow stack");

    // one word at a time: intake closes right after a word is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while busy");

    // depth never exceeds the cell count
    a_depth_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:24] <= 11'd1024))
        else $error("stack depth beyond capacity");

endmodule

`default_nettype wire

>>> rtl/core/dbmc_ctrl.sv
// ----------------------------------------------------------------------------
// dbmc_ctrl
// sequencer of the maze carver: walks each item through the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module dbmc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire dbmc_pkg::sts_t sts,
    output dbmc_pkg::cmd_t     cmd
);

    dbmc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dbmc_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dbmc_pkg::ST_CLEAR: begin
                if (sts.clr_last) state_next = dbmc_pkg::ST_IDLE;
            end
            dbmc_pkg::ST_SWEEP: begin
                if (sts.clr_last) state_next = dbmc_pkg::ST_START_FIN;
            end
            dbmc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (sts.in_action)
                        dbmc_pkg::ACT_START: state_next = dbmc_pkg::ST_SWEEP;
                        dbmc_pkg::ACT_STEP:  state_next = sts.stack_empty ?
                                                 dbmc_pkg::ST_FINISH : dbmc_pkg::ST_POP;
                        dbmc_pkg::ACT_READ:  state_next = dbmc_pkg::ST_CELL_RD;
                        default:             state_next = dbmc_pkg::ST_FINISH;
                    endcase
                end
            end
            dbmc_pkg::ST_START_FIN: state_next = dbmc_pkg::ST_FINISH;
            dbmc_pkg::ST_POP:       state_next = dbmc_pkg::ST_POP_CAP;
            dbmc_pkg::ST_POP_CAP:   state_next = dbmc_pkg::ST_DIV;
            dbmc_pkg::ST_DIV: begin
                if (sts.div_last) state_next = dbmc_pkg::ST_NB_RD;
            end
            dbmc_pkg::ST_NB_RD:     state_next = dbmc_pkg::ST_NB_CAP;
            dbmc_pkg::ST_NB_CAP: begin
                if (sts.nb_last) begin
                    state_next = sts.any_nb ? dbmc_pkg::ST_WR_CUR : dbmc_pkg::ST_FINISH;
                end else begin
                    state_next = dbmc_pkg::ST_NB_RD;
                end
            end
            dbmc_pkg::ST_WR_CUR:    state_next = dbmc_pkg::ST_WR_NB;
            dbmc_pkg::ST_WR_NB:     state_next = dbmc_pkg::ST_FINISH;
            dbmc_pkg::ST_CELL_RD:   state_next = dbmc_pkg::ST_CELL_CAP;
            dbmc_pkg::ST_CELL_CAP:  state_next = dbmc_pkg::ST_FINISH;
            dbmc_pkg::ST_FINISH: begin
                if (sts.out_free) state_next = dbmc_pkg::ST_IDLE;
            end
            default: state_next = dbmc_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            dbmc_pkg::ST_CLEAR, dbmc_pkg::ST_SWEEP: cmd.clr_write = 1'b1;
            dbmc_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.take_in = s_tvalid;
                cmd.clr_init = s_tvalid && (sts.in_action == dbmc_pkg::ACT_START);
            end
            dbmc_pkg::ST_START_FIN: cmd.start_fin = 1'b1;
            dbmc_pkg::ST_POP:       cmd.pop_rd    = 1'b1;
            dbmc_pkg::ST_POP_CAP:   cmd.pop_cap   = 1'b1;
            dbmc_pkg::ST_DIV:       cmd.div_step  = 1'b1;
            dbmc_pkg::ST_NB_RD:     cmd.nb_rd     = 1'b1;
            dbmc_pkg::ST_NB_CAP:    cmd.nb_cap    = 1'b1;
            dbmc_pkg::ST_WR_CUR:    cmd.wr_cur    = 1'b1;
            dbmc_pkg::ST_WR_NB:     cmd.wr_nb     = 1'b1;
            dbmc_pkg::ST_CELL_RD:   cmd.cell_rd   = 1'b1;
            dbmc_pkg::ST_CELL_CAP:  cmd.cell_cap  = 1'b1;
            dbmc_pkg::ST_FINISH:    cmd.res_load  = sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/dbmc_dp.sv
// ----------------------------------------------------------------------------
// dbmc_dp
// datapath: cell and stack memories, grid registers, divider, result register
// ----------------------------------------------------------------------------
`default_nettype none

module dbmc_dp (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dbmc_pkg::cmd_t        cmd,
    output dbmc_pkg::sts_t             sts,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_addr,
    input  wire logic [5:0]            cfg_wdata,
    input  wire logic [31:0]           s_tdata,
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [39:0]                m_tdata,
    output logic [0:0]                 m_tuser,
    output logic                       m_tlast
);

    localparam int CW = dbmc_pkg::CELL_W;
    localparam int DW = dbmc_pkg::DEPTH_W;
    localparam int NW = dbmc_pkg::DIM_W;
    localparam int WW = dbmc_pkg::WALL_W;

    // memories: cell entry is {visited, walls}
    logic [WW:0]   cell_mem  [dbmc_pkg::CELL_CAP];
    logic [CW-1:0] stack_mem [dbmc_pkg::CELL_CAP];

    logic [NW-1:0] cols_reg, rows_reg;
    logic [NW-1:0] cols_eff, rows_eff;
    logic [DW-1:0] count_reg, count_next;
    logic [CW-1:0] clr_cnt_reg;
    logic [dbmc_pkg::RND_W-1:0] rnd_reg;
    logic [CW-1:0] rd_idx_reg;
    logic [CW-1:0] cur_reg;
    logic [CW-1:0] quo_reg;
    logic [NW-1:0] rem_reg;
    logic [dbmc_pkg::DIVC_W-1:0] div_cnt_reg;
    logic [2:0]    nb_idx_reg;
    logic [3:0]    nb_ok_reg;
    logic [WW-1:0] nb_walls_reg [4];
    logic [WW:0]   cur_cell_reg;
    logic [WW:0]   cell_rdata_reg;
    logic [CW-1:0] stack_rdata_reg;

    logic          adv_reg;
    logic [CW-1:0] from_reg, to_reg;
    logic [WW-1:0] walls_reg;

    logic          out_valid_reg;
    logic          out_done_reg, out_adv_reg;
    logic [CW-1:0] out_from_reg, out_to_reg;
    logic [WW-1:0] out_walls_reg;
    logic [DW-1:0] out_depth_reg;

    // grid clamp
    always_comb begin
        if (cols_reg == '0) begin
            cols_eff = NW'(1);
        end else if (cols_reg > NW'(dbmc_pkg::MAX_COLS)) begin
            cols_eff = NW'(dbmc_pkg::MAX_COLS);
        end else begin
            cols_eff = cols_reg;
        end
        if (rows_reg == '0) begin
            rows_eff = NW'(1);
        end else if (rows_reg > NW'(dbmc_pkg::MAX_ROWS)) begin
            rows_eff = NW'(dbmc_pkg::MAX_ROWS);
        end else begin
            rows_eff = rows_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= NW'(20);
            rows_reg <= NW'(15);
        end else if (cfg_wr_en) begin
            if (cfg_addr == dbmc_pkg::REG_COLS) begin
                cols_reg <= cfg_wdata;
            end else begin
                rows_reg <= cfg_wdata;
            end
        end
    end

    // neighbour geometry, x = rem_reg, y = quo_reg after the division
    logic [3:0]    in_grid;
    logic [CW-1:0] nb_addr [4];
    logic [CW:0]   y_ext, rows_ext;
    always_comb begin
        y_ext    = {1'b0, quo_reg};
        rows_ext = (CW+1)'(rows_eff);
        in_grid[dbmc_pkg::DIR_L] = (rem_reg != '0) && (y_ext < rows_ext);
        in_grid[dbmc_pkg::DIR_R] = ((NW+1)'(rem_reg) + (NW+1)'(1) < (NW+1)'(cols_eff))
                                   && (y_ext < rows_ext);
        in_grid[dbmc_pkg::DIR_U] = (quo_reg != '0) && (y_ext - (CW+1)'(1) < rows_ext);
        in_grid[dbmc_pkg::DIR_D] = (y_ext + (CW+1)'(1) < rows_ext);
        nb_addr[dbmc_pkg::DIR_L] = cur_reg - CW'(1);
        nb_addr[dbmc_pkg::DIR_R] = cur_reg + CW'(1);
        nb_addr[dbmc_pkg::DIR_U] = cur_reg - CW'(cols_eff);
        nb_addr[dbmc_pkg::DIR_D] = cur_reg + CW'(cols_eff);
    end

    logic [1:0] dir_sel;
    assign dir_sel = dbmc_pkg::pick_dir(nb_ok_reg, rnd_reg);

    // cell memory ports
    logic          cell_we, cell_re;
    logic [CW-1:0] cell_waddr, cell_raddr;
    logic [WW:0]   cell_wdata;
    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = clr_cnt_reg;
        cell_wdata = {1'b0, dbmc_pkg::W_ALL};
        if (cmd.clr_write) begin
            cell_we = 1'b1;
        end else if (cmd.start_fin) begin
            cell_we    = 1'b1;
            cell_waddr = '0;
            cell_wdata = {1'b1, dbmc_pkg::W_ALL};
        end else if (cmd.wr_cur) begin
            cell_we    = 1'b1;
            cell_waddr = cur_reg;
            cell_wdata = {cur_cell_reg[WW],
                          cur_cell_reg[WW-1:0] & ~dbmc_pkg::mine_wall(dir_sel)};
        end else if (cmd.wr_nb) begin
            cell_we    = 1'b1;
            cell_waddr = nb_addr[dir_sel];
            cell_wdata = {1'b1, nb_walls_reg[dir_sel] & ~dbmc_pkg::their_wall(dir_sel)};
        end
        cell_re    = cmd.nb_rd || cmd.cell_rd;
        if (cmd.cell_rd) begin
            cell_raddr = rd_idx_reg;
        end else if (nb_idx_reg[2]) begin
            cell_raddr = cur_reg;
        end else begin
            cell_raddr = nb_addr[nb_idx_reg[1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
        if (cell_re) cell_rdata_reg <= cell_mem[cell_raddr];
    end

    // stack memory ports
    logic          stk_we;
    logic [CW-1:0] stk_waddr, stk_wdata, stk_raddr;
    logic          stk_room;
    assign stk_room  = count_reg < DW'(dbmc_pkg::CELL_CAP);
    assign stk_we    = cmd.start_fin || (cmd.wr_nb && stk_room);
    assign stk_waddr = cmd.start_fin ? '0 : count_reg[CW-1:0];
    assign stk_wdata = cmd.start_fin ? '0 : nb_addr[dir_sel];
    assign stk_raddr = count_next[CW-1:0];

    always_ff @(posedge aclk) begin
        if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
        if (cmd.pop_rd) stack_rdata_reg <= stack_mem[stk_raddr];
    end

    // stack depth
    always_comb begin
        count_next = count_reg;
        if (cmd.clr_init) begin
            count_next = '0;
        end else if (cmd.start_fin) begin
            count_next = DW'(1);
        end else if (cmd.pop_rd) begin
            count_next = count_reg - DW'(1);
        end else if ((cmd.wr_cur || cmd.wr_nb) && stk_room) begin
            count_next = count_reg + DW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            clr_cnt_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.clr_init) begin
                clr_cnt_reg <= '0;
            end else if (cmd.clr_write) begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
        end
    end

    // item registers, divider, neighbour capture
    logic [NW:0] rem_try;
    assign rem_try = {rem_reg, quo_reg[CW-1]};

    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            rnd_reg    <= s_tdata[15:0];
            rd_idx_reg <= s_tdata[16 +: CW];
            adv_reg    <= 1'b0;
            from_reg   <= '0;
            to_reg     <= '0;
            walls_reg  <= '0;
        end
        if (cmd.pop_cap) begin
            cur_reg     <= stack_rdata_reg;
            from_reg    <= stack_rdata_reg;
            quo_reg     <= stack_rdata_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            nb_idx_reg  <= '0;
            nb_ok_reg   <= '0;
        end
        if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + dbmc_pkg::DIVC_W'(1);
            if (rem_try >= (NW+1)'(cols_eff)) begin
                rem_reg <= NW'(rem_try - (NW+1)'(cols_eff));
                quo_reg <= {quo_reg[CW-2:0], 1'b1};
            end else begin
                rem_reg <= NW'(rem_try);
                quo_reg <= {quo_reg[CW-2:0], 1'b0};
            end
        end
        if (cmd.nb_cap) begin
            nb_idx_reg <= nb_idx_reg + 3'd1;
            if (nb_idx_reg[2]) begin
                cur_cell_reg <= cell_rdata_reg;
            end else begin
                nb_walls_reg[nb_idx_reg[1:0]] <= cell_rdata_reg[WW-1:0];
                nb_ok_reg[nb_idx_reg[1:0]]    <= in_grid[nb_idx_reg[1:0]]
                                                 && !cell_rdata_reg[WW];
            end
        end
        if (cmd.wr_nb) begin
            adv_reg <= 1'b1;
            to_reg  <= nb_addr[dir_sel];
        end
        if (cmd.cell_cap) begin
            walls_reg <= cell_rdata_reg[WW-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            out_done_reg  <= (count_reg == '0);
            out_adv_reg   <= adv_reg;
            out_from_reg  <= from_reg;
            out_to_reg    <= to_reg;
            out_walls_reg <= walls_reg;
            out_depth_reg <= count_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tlast    = out_done_reg;
    assign m_tuser[0] = out_adv_reg;
    assign m_tdata    = {5'd0, out_depth_reg, out_walls_reg, out_to_reg, out_from_reg};

    always_comb begin
        sts             = '0;
        sts.clr_last    = (clr_cnt_reg == CW'(dbmc_pkg::CELL_CAP - 1));
        sts.div_last    = (div_cnt_reg == dbmc_pkg::DIVC_W'(CW - 1));
        sts.nb_last     = nb_idx_reg[2];
        sts.any_nb      = |nb_ok_reg;
        sts.stack_empty = (count_reg == '0);
        sts.in_action   = s_tuser;
        sts.out_free    = !out_valid_reg || m_tready;
    end

endmodule

`default_nettype wire
